// File: sv/bitmap_text_renderer_macros.svh
// Assertion macros for the bitmap text renderer.
// Depends on nothing; files that check their logic include it by name.
`ifndef BITMAP_TEXT_RENDERER_MACROS_SVH
`define BITMAP_TEXT_RENDERER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock, off during reset.
`define BTR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the rising clock, off during reset.
`define BTR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BTR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/btr_pkg.sv
// Shared constants, codes and types of the bitmap text renderer.
// Used by the channel interfaces and by the renderer module; depends on nothing.
package btr_pkg;

    // Font and table geometry.
    localparam int RANGE_ENTRIES = 16;
    localparam int GLYPH_COUNT   = 512;   // power of two: glyph index wraps by truncation
    localparam int GLYPH_ROWS    = 16;
    localparam int CHAR_WIDTH    = 8;

    // Derived widths.
    localparam int RE_IW  = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int RE_CW  = $clog2(RANGE_ENTRIES + 1);
    localparam int GLY_W  = $clog2(GLYPH_COUNT);
    localparam int ROW_W  = $clog2(GLYPH_ROWS);
    localparam int GS_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GS_AW  = $clog2(GS_DEPTH);

    // Field widths of the channels.
    localparam int CMD_W   = 2;
    localparam int CODE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int BASE_W  = 9;
    localparam int SEL_W   = 9;
    localparam int RSEL_W  = 4;
    localparam int MASK_W  = 8;
    localparam int POS_W   = 12;
    localparam int ROWY_W  = 13;
    localparam int COLOR_W = 32;
    localparam int SW_W    = 13;
    localparam int RC_W    = 5;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 32;

    localparam logic [POS_W-1:0] CUR_MAX = '1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_DRAW     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_RNG = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CURSOR   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH = 2'd0;
    localparam logic [CFG_IW-1:0] REG_TEXT_COLOR   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_RANGE_COUNT  = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_SHOW
    } t_state;

endpackage

// File: sv/btr_if.sv
// Valid/ready channel interfaces of the bitmap text renderer.
// Depends on btr_pkg for the field widths.

// Command channel: one item per transfer.
interface btr_in_if;
    logic                         valid;
    logic                         ready;
    logic [btr_pkg::CMD_W-1:0]    cmd;
    logic [btr_pkg::CODE_W-1:0]   char_code;
    logic [btr_pkg::SLOT_W-1:0]   entry_slot;
    logic [btr_pkg::CODE_W-1:0]   range_start;
    logic [btr_pkg::CODE_W-1:0]   range_length;
    logic [btr_pkg::BASE_W-1:0]   glyph_base;
    logic [btr_pkg::SEL_W-1:0]    glyph_select;
    logic [btr_pkg::RSEL_W-1:0]   row_select;
    logic [btr_pkg::MASK_W-1:0]   row_bits;
    logic [btr_pkg::POS_W-1:0]    new_x;
    logic [btr_pkg::POS_W-1:0]    new_y;

    modport source (
        output valid, cmd, char_code, entry_slot, range_start, range_length,
               glyph_base, glyph_select, row_select, row_bits, new_x, new_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, char_code, entry_slot, range_start, range_length,
               glyph_base, glyph_select, row_select, row_bits, new_x, new_y,
        output ready
    );
endinterface

// Glyph row channel: one row per transfer.
interface btr_out_if;
    logic                          valid;
    logic                          ready;
    logic [btr_pkg::POS_W-1:0]     row_x;
    logic [btr_pkg::ROWY_W-1:0]    row_y;
    logic [btr_pkg::MASK_W-1:0]    row_mask;
    logic [btr_pkg::COLOR_W-1:0]   pixel_color;
    logic                          last_row;

    modport source (
        output valid, row_x, row_y, row_mask, pixel_color, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_x, row_y, row_mask, pixel_color, last_row,
        output ready
    );
endinterface

// Configuration write channel.
interface btr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [btr_pkg::CFG_IW-1:0]   index;
    logic [btr_pkg::CFG_DW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/btr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bitmap_text_renderer.sv
// Bitmap text renderer: a draw item searches k range entries, then reads and shows its rows,
// where k is the number of range entries compared (one per cycle, at most
// range_count, capped at RANGE_ENTRIES); rows then leave one per cycle while the sink is ready.
// Load and cursor items are taken in idle and leave the sequencer idle. The block accepts no item while drawing.
// i_rst_n is synchronous, active low: cursor and sequencer clear, registers take
// their defaults; the range table and glyph store stay undefined until written.
`include "bitmap_text_renderer_macros.svh"

module bitmap_text_renderer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    btr_in_if.sink    i_in,
    btr_cfg_if.sink   i_cfg,
    btr_out_if.source o_out
);

    // Configuration registers.
    logic [btr_pkg::SW_W-1:0]    r_screen_width;
    logic [btr_pkg::COLOR_W-1:0] r_text_color;
    logic [btr_pkg::RC_W-1:0]    r_range_count;

    // Range table, written by load-range items.
    logic [btr_pkg::CODE_W-1:0] r_rng_start [btr_pkg::RANGE_ENTRIES];
    logic [btr_pkg::CODE_W-1:0] r_rng_len   [btr_pkg::RANGE_ENTRIES];
    logic [btr_pkg::BASE_W-1:0] r_rng_base  [btr_pkg::RANGE_ENTRIES];

    // Sequencer and cursor state.
    btr_pkg::t_state            r_state, n_state;
    logic [btr_pkg::RE_CW-1:0]  r_idx, n_idx;
    logic [btr_pkg::RE_CW-1:0]  r_lim, n_lim;
    logic [btr_pkg::ROW_W-1:0]  r_row, n_row;
    logic [btr_pkg::GLY_W-1:0]  r_glyph, n_glyph;
    logic [btr_pkg::CODE_W-1:0] r_code, n_code;
    logic [btr_pkg::POS_W-1:0]  r_cur_x, n_cur_x;
    logic [btr_pkg::POS_W-1:0]  r_cur_y, n_cur_y;

    // Glyph store port signals.
    logic                       gs_we;
    logic [btr_pkg::GS_AW-1:0]  gs_waddr;
    logic                       gs_re;
    logic [btr_pkg::GS_AW-1:0]  gs_raddr;
    logic [btr_pkg::MASK_W-1:0] gs_rdata;

    // Handshake terms.
    logic in_xfer;
    logic out_xfer;
    logic last_row;

    // Shared compare unit of the range search.
    logic [btr_pkg::RE_IW-1:0]  ent_sel;
    logic [btr_pkg::CODE_W:0]   ent_diff;
    logic                       ent_hit;
    logic [btr_pkg::GLY_W-1:0]  ent_glyph;

    // Cursor step terms.
    logic [btr_pkg::POS_W:0]    step_x;
    logic [btr_pkg::POS_W+1:0]  step_x2;
    logic [btr_pkg::POS_W:0]    step_y;
    logic                       step_wrap;

    // Row address inside the glyph store.
    function automatic logic [btr_pkg::GS_AW-1:0] gs_addr(
        input logic [btr_pkg::GLY_W-1:0] glyph,
        input logic [btr_pkg::ROW_W-1:0] row
    );
        gs_addr = btr_pkg::GS_AW'(btr_pkg::GS_AW'(glyph) * btr_pkg::GS_AW'(btr_pkg::GLYPH_ROWS))
                + btr_pkg::GS_AW'(row);
    endfunction

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign last_row = (r_row == btr_pkg::ROW_W'(btr_pkg::GLYPH_ROWS - 1));

    // Configuration writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= btr_pkg::SW_W'(640);
            r_text_color   <= '1;
            r_range_count  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                btr_pkg::REG_SCREEN_WIDTH: r_screen_width <= i_cfg.data[btr_pkg::SW_W-1:0];
                btr_pkg::REG_TEXT_COLOR:   r_text_color   <= i_cfg.data;
                btr_pkg::REG_RANGE_COUNT:  r_range_count  <= i_cfg.data[btr_pkg::RC_W-1:0];
                default: ;
            endcase
        end
    end

    // Range table writes; a slot beyond the table is ignored.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.cmd == btr_pkg::CMD_LOAD_RNG
                && 32'(i_in.entry_slot) < 32'(btr_pkg::RANGE_ENTRIES)) begin
            r_rng_start[btr_pkg::RE_IW'(i_in.entry_slot)] <= i_in.range_start;
            r_rng_len[btr_pkg::RE_IW'(i_in.entry_slot)]   <= i_in.range_length;
            r_rng_base[btr_pkg::RE_IW'(i_in.entry_slot)]  <= i_in.glyph_base;
        end
    end

    // One range entry per cycle: code is in range when code - start neither
    // borrows nor reaches the length.
    assign ent_sel   = r_idx[btr_pkg::RE_IW-1:0];
    assign ent_diff  = {1'b0, r_code} - {1'b0, r_rng_start[ent_sel]};
    assign ent_hit   = !ent_diff[btr_pkg::CODE_W]
                     && (ent_diff[btr_pkg::CODE_W-1:0] < r_rng_len[ent_sel]);
    assign ent_glyph = btr_pkg::GLY_W'(r_rng_base[ent_sel])
                     + btr_pkg::GLY_W'(ent_diff[btr_pkg::CODE_W-1:0]);

    // Cursor advance after the final row; wrap at the screen edge or past the
    // coordinate range, with y saturating.
    assign step_x    = {1'b0, r_cur_x} + (btr_pkg::POS_W+1)'(btr_pkg::CHAR_WIDTH);
    assign step_x2   = {1'b0, step_x} + (btr_pkg::POS_W+2)'(btr_pkg::CHAR_WIDTH);
    assign step_wrap = step_x[btr_pkg::POS_W]
                     || (step_x2 >= (btr_pkg::POS_W+2)'(r_screen_width));
    assign step_y    = {1'b0, r_cur_y} + (btr_pkg::POS_W+1)'(btr_pkg::GLYPH_ROWS);

    // Glyph store writes come straight from load-row items.
    assign gs_we    = in_xfer && i_in.cmd == btr_pkg::CMD_LOAD_ROW
                    && 32'(i_in.glyph_select) < 32'(btr_pkg::GLYPH_COUNT)
                    && 32'(i_in.row_select) < 32'(btr_pkg::GLYPH_ROWS);
    assign gs_waddr = gs_addr(btr_pkg::GLY_W'(i_in.glyph_select),
                              btr_pkg::ROW_W'(i_in.row_select));

    btr_ram #(
        .WIDTH (btr_pkg::MASK_W),
        .DEPTH (btr_pkg::GS_DEPTH)
    ) u_glyph_store (
        .i_clk   (i_clk),
        .i_we    (gs_we),
        .i_waddr (gs_waddr),
        .i_wdata (i_in.row_bits),
        .i_re    (gs_re),
        .i_raddr (gs_raddr),
        .o_rdata (gs_rdata)
    );

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btr_pkg::ST_IDLE;
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            r_state <= n_state;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

    // Working registers of the current character.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_lim   <= n_lim;
        r_row   <= n_row;
        r_glyph <= n_glyph;
        r_code  <= n_code;
    end

    // Next state, glyph store reads and handshakes.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_row      = r_row;
        n_glyph    = r_glyph;
        n_code     = r_code;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        gs_re      = 1'b0;
        gs_raddr   = gs_addr(r_glyph, r_row);
        i_in.ready = 1'b0;

        unique case (r_state)
            btr_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    unique case (i_in.cmd)
                        btr_pkg::CMD_DRAW: begin
                            n_code  = i_in.char_code;
                            n_idx   = '0;
                            n_row   = '0;
                            n_glyph = '0;
                            if (32'(r_range_count) > 32'(btr_pkg::RANGE_ENTRIES)) begin
                                n_lim = btr_pkg::RE_CW'(btr_pkg::RANGE_ENTRIES);
                            end else begin
                                n_lim = btr_pkg::RE_CW'(r_range_count);
                            end
                            n_state = (r_range_count == '0) ? btr_pkg::ST_READ
                                                            : btr_pkg::ST_SEARCH;
                        end
                        btr_pkg::CMD_CURSOR: begin
                            n_cur_x = i_in.new_x;
                            n_cur_y = i_in.new_y;
                        end
                        default: ;
                    endcase
                end
            end
            btr_pkg::ST_SEARCH: begin
                // First hit wins; no hit leaves glyph zero.
                if (ent_hit) begin
                    n_glyph = ent_glyph;
                    n_state = btr_pkg::ST_READ;
                end else if (r_idx + 1'b1 == r_lim) begin
                    n_state = btr_pkg::ST_READ;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            btr_pkg::ST_READ: begin
                gs_re   = 1'b1;
                n_state = btr_pkg::ST_SHOW;
            end
            btr_pkg::ST_SHOW: begin
                // The next row is fetched during the transfer of this one.
                if (o_out.ready) begin
                    if (last_row) begin
                        n_state = btr_pkg::ST_IDLE;
                        if (step_wrap) begin
                            n_cur_x = '0;
                            n_cur_y = step_y[btr_pkg::POS_W] ? btr_pkg::CUR_MAX
                                                             : step_y[btr_pkg::POS_W-1:0];
                        end else begin
                            n_cur_x = step_x[btr_pkg::POS_W-1:0];
                        end
                    end else begin
                        n_row    = r_row + 1'b1;
                        gs_re    = 1'b1;
                        gs_raddr = gs_addr(r_glyph, r_row + 1'b1);
                    end
                end
            end
            default: n_state = btr_pkg::ST_IDLE;
        endcase
    end

    // Result payload comes from registers and the glyph store read register.
    assign o_out.valid       = (r_state == btr_pkg::ST_SHOW);
    assign o_out.row_x       = r_cur_x;
    assign o_out.row_y       = btr_pkg::ROWY_W'(r_cur_y) + btr_pkg::ROWY_W'(r_row);
    assign o_out.row_mask    = gs_rdata;
    assign o_out.pixel_color = r_text_color;
    assign o_out.last_row    = last_row;

    // A row on offer means no command is taken.
    `BTR_ASSERT_IMP(a_no_accept_while_show, i_clk, i_rst_n, o_out.valid, !i_in.ready, "command taken while a row is on offer")
    // The final row ends the character.
    `BTR_ASSERT_NXT(a_last_row_ends, i_clk, i_rst_n, out_xfer && last_row, r_state == btr_pkg::ST_IDLE, "sequencer did not return to idle after the final row")
    // Rows advance by one per transfer.
    `BTR_ASSERT_NXT(a_row_step, i_clk, i_rst_n, out_xfer && !last_row, (r_row == $past(r_row) + 1'b1) && o_out.valid, "row counter did not advance by one")
    // The search never looks past the searched entries.
    `BTR_ASSERT_IMP(a_search_bound, i_clk, i_rst_n, r_state == btr_pkg::ST_SEARCH, r_idx < r_lim, "range search past the searched entries")
    // A draw command always starts a character.
    `BTR_ASSERT_NXT(a_draw_starts, i_clk, i_rst_n, in_xfer && i_in.cmd == btr_pkg::CMD_DRAW, r_state == btr_pkg::ST_SEARCH || r_state == btr_pkg::ST_READ, "draw command did not start a character")

endmodule
